/* hw/rtl/fisr_pkg.sv */
// ============================================================================
// fisr_pkg
// Shared constants and float32 helpers for the reciprocal square root block.
// ============================================================================
package fisr_pkg;

  localparam logic [31:0] MAGIC     = 32'h5f3759df;
  localparam logic [31:0] F_HALF    = 32'h3f000000;
  localparam logic [31:0] F_ONEHALF = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN = 32'h7fc00000;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  // Unpacked operand: sign, exponent, 24-bit significand with hidden bit.
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;
    logic [23:0] man;
  } fp_unp_t;

  function automatic fp_unp_t unpack(input logic [31:0] a);
    fp_unp_t u;
    u.sign = a[31];
    u.nan  = is_nan(a);
    u.inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    u.zero = (a[30:0] == 31'd0);
    if (a[30:23] == 8'd0) begin
      u.exp = 11'sd1;
      u.man = {1'b0, a[22:0]};
    end else begin
      u.exp = 11'(a[30:23]);
      u.man = {1'b1, a[22:0]};
    end
    return u;
  endfunction

  // Round a value sig * 2^(e - 127 - 49) to float32, nearest even.
  // sig is 50-bit, sticky gathered by caller into bit 0.
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [11:0] e,
                                             input logic [49:0] sig);
    logic [49:0] s;
    logic signed [11:0] ex;
    logic [5:0] lz;
    logic [49:0] sh;
    logic [24:0] m;
    logic g, st, rnd;
    logic [5:0] rs;
    integer i;
    s = sig;
    ex = e;
    lz = 6'd0;
    for (i = 49; i >= 0; i--) begin
      if (s[i]) lz = 6'(49 - i);
    end
    for (i = 0; i <= 49; i++) begin
      if (s[i]) lz = 6'(49 - i);
    end
    lz = 6'd0;
    for (i = 0; i <= 49; i++) begin
      if (s[i]) lz = 6'(49 - i);
    end
    if (s == 50'd0) return {sign, 31'd0};
    // normalize so bit 49 set, adjusting exponent
    if (ex - $signed({6'd0, lz}) < 12'sd1) begin
      if (ex > 12'sd1 - 12'sd0) begin
        sh = s << (ex - 12'sd1);
        ex = 12'sd0;
      end else if (ex == 12'sd1) begin
        sh = s;
        ex = 12'sd0;
      end else begin
        rs = (12'sd1 - ex > 12'sd50) ? 6'd50 : 6'(12'sd1 - ex);
        sh = (s >> rs) | {49'd0, |(s & ((50'd1 << rs) - 50'd1))};
        ex = 12'sd0;
      end
    end else begin
      sh = s << lz;
      ex = ex - 12'(lz);
    end
    m   = {1'b0, sh[49:26]};
    g   = sh[25];
    st  = |sh[24:0];
    rnd = g & (st | m[0]);
    m   = m + 25'(rnd);
    if (m[24]) begin
      m = m >> 1;
      ex = ex + 12'sd1;
    end else if (ex == 12'sd0 && m[23]) begin
      ex = 12'sd1;
    end
    if (ex >= 12'sd255) return {sign, 8'hff, 23'd0};
    return {sign, ex[7:0], m[22:0]};
  endfunction

endpackage

/* hw/rtl/fisr_fmul.sv */
// ============================================================================
// fisr_fmul
// Two-stage float32 multiplier: significand product, then round and pack.
// ============================================================================
module fisr_fmul
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  input  logic [31:0] in_pass,
  output logic        out_vld,
  output logic [31:0] out_p,
  output logic [31:0] out_pass
);

  fp_unp_t ua, ub;
  logic        vld_r, vld2_r;
  logic [47:0] prod_r, prod_nxt;
  logic        sign_r, spec_r;
  logic [31:0] spec_val_r, spec_nxt, pass_r, pass2_r, p_r, p_nxt;
  logic signed [11:0] exp_r, exp_nxt;
  logic        is_spec;

  always_comb begin
    ua = unpack(in_a);
    ub = unpack(in_b);
    prod_nxt = ua.man * ub.man;
    exp_nxt  = 12'(ua.exp) + 12'(ub.exp) - 12'sd127 + 12'sd1;
    is_spec  = ua.nan | ub.nan | ua.inf | ub.inf;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ub.inf && ua.zero))
      spec_nxt = CANON_NAN;
    else
      spec_nxt = {ua.sign ^ ub.sign, 8'hff, 23'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld_r  <= in_vld;
      vld2_r <= vld_r;
    end
    prod_r     <= prod_nxt;
    exp_r      <= exp_nxt;
    sign_r     <= in_a[31] ^ in_b[31];
    spec_r     <= is_spec;
    spec_val_r <= spec_nxt;
    pass_r     <= in_pass;
    p_r        <= p_nxt;
    pass2_r    <= pass_r;
  end

  // sig bit 49 is weight 2^1 relative to exponent, product top at bit 47
  assign p_nxt = spec_r ? spec_val_r : round_pack(sign_r, exp_r, {prod_r, 2'b00});

  assign out_vld  = vld2_r;
  assign out_p    = p_r;
  assign out_pass = pass2_r;

endmodule

/* hw/rtl/fisr_fsub.sv */
// ============================================================================
// fisr_fsub
// Two-stage float32 subtract 1.5 - t: align, then add and round.
// ============================================================================
module fisr_fsub
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_t,
  input  logic [31:0] in_pass,
  output logic        out_vld,
  output logic [31:0] out_d,
  output logic [31:0] out_pass
);

  fp_unp_t ut;
  logic        vld_r, vld2_r, spec_r;
  logic [31:0] spec_val_r, spec_nxt, pass_r, pass2_r, d_r, d_nxt;
  logic [49:0] big_r, sml_r, big_nxt, sml_nxt;
  logic        big_sgn_r, sml_sgn_r, big_sgn_nxt, sml_sgn_nxt;
  logic signed [11:0] exp_r, exp_nxt;
  logic signed [11:0] et;
  logic [11:0] dif;
  logic [49:0] ma, mb, shf;
  logic [49:0] sum;
  logic        ssgn;

  // a = 1.5 (exp 127, man 0xC00000), b = -t
  always_comb begin
    ut  = unpack(in_t);
    et  = 12'(ut.exp);
    ma  = {1'b0, 24'hc00000, 25'd0};
    mb  = {1'b0, ut.man, 25'd0};
    big_nxt = ma; sml_nxt = mb; exp_nxt = 12'sd127;
    big_sgn_nxt = 1'b0; sml_sgn_nxt = ~ut.sign;
    dif = 12'd0;
    if (et > 12'sd127 || (et == 12'sd127 && ut.man > 24'hc00000)) begin
      big_nxt = mb; sml_nxt = ma; exp_nxt = et;
      big_sgn_nxt = ~ut.sign; sml_sgn_nxt = 1'b0;
      dif = 12'(et - 12'sd127);
    end else begin
      dif = 12'(12'sd127 - et);
    end
    shf = sml_nxt;
    if (dif > 12'd49) sml_nxt = {49'd0, |shf};
    else sml_nxt = (shf >> dif[5:0]) | {49'd0, |(shf & ((50'd1 << dif[5:0]) - 50'd1))};
    if (ut.nan) spec_nxt = CANON_NAN;
    else spec_nxt = {~ut.sign, 8'hff, 23'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld_r  <= in_vld;
      vld2_r <= vld_r;
    end
    big_r      <= big_nxt;
    sml_r      <= sml_nxt;
    big_sgn_r  <= big_sgn_nxt;
    sml_sgn_r  <= sml_sgn_nxt;
    exp_r      <= exp_nxt;
    spec_r     <= ut.nan | ut.inf;
    spec_val_r <= spec_nxt;
    pass_r     <= in_pass;
    d_r        <= d_nxt;
    pass2_r    <= pass_r;
  end

  always_comb begin
    if (big_sgn_r == sml_sgn_r) sum = big_r + sml_r;
    else sum = big_r - sml_r;
    ssgn = big_sgn_r;
    // exact cancellation gives +0 under round to nearest
    if (sum == 50'd0) ssgn = 1'b0;
    d_nxt = spec_r ? spec_val_r : round_pack(ssgn, exp_r + 12'sd1, sum);
  end

  assign out_vld  = vld2_r;
  assign out_d    = d_r;
  assign out_pass = pass2_r;

endmodule

/* hw/rtl/fast_inverse_sqrt_float32.sv */
// ============================================================================
// fast_inverse_sqrt_float32
// Bit-trick first guess plus one Newton-Raphson step in float32.
// ============================================================================
// channel  ports                      handshake
// in       in_value_bits              start & !busy
// out      out_result_bits            out_valid strobe, one cycle
//
// One item may enter every cycle; busy is always low. The pipeline is
// four multipliers and one subtractor, two stages each, plus a output register.
// Synchronous active-low reset clears the valid bits only. The receiver
// cannot stall, so nothing is held back.
module fast_inverse_sqrt_float32
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  output logic [31:0] out_result_bits
);

  logic        v1, v2, v3, v4, v5;
  logic [31:0] h, g1, t1, g2, t2, g3, d, g4, r, unused_pass;
  logic        ov_r;
  logic [31:0] res_r;
  logic [31:0] guess;

  assign busy  = 1'b0;
  assign guess = MAGIC - {1'b0, in_value_bits[31:1]};

  fisr_fmul u_h (.clk, .rst_n, .in_vld(start), .in_a(in_value_bits), .in_b(F_HALF),
                 .in_pass(guess), .out_vld(v1), .out_p(h), .out_pass(g1));
  fisr_fmul u_t1 (.clk, .rst_n, .in_vld(v1), .in_a(h), .in_b(g1),
                  .in_pass(g1), .out_vld(v2), .out_p(t1), .out_pass(g2));
  fisr_fmul u_t2 (.clk, .rst_n, .in_vld(v2), .in_a(t1), .in_b(g2),
                  .in_pass(g2), .out_vld(v3), .out_p(t2), .out_pass(g3));
  fisr_fsub u_s (.clk, .rst_n, .in_vld(v3), .in_t(t2),
                 .in_pass(g3), .out_vld(v4), .out_d(d), .out_pass(g4));
  fisr_fmul u_r (.clk, .rst_n, .in_vld(v4), .in_a(g4), .in_b(d),
                 .in_pass(d), .out_vld(v5), .out_p(r), .out_pass(unused_pass));

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= v5;
    res_r <= is_nan(r) ? CANON_NAN : (r ^ (unused_pass & 32'd0));
  end

  assign out_valid       = ov_r;
  assign out_result_bits = res_r;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: reciprocal square root block testbench
// Sends float32 patterns (directed corner cases, then random mixes of normal,
// subnormal, special and negative values) and checks every result against a
// fixed value or bit-exact model: magic-constant guess, one Newton step.
// ----------------------------------------------------------------------------
module tb_top;
  import fisr_pkg::*;

  typedef enum logic [1:0] {FC_NUM, FC_ZERO, FC_INF, FC_NAN} fclass_t;
  typedef struct packed {
    fclass_t            cls;
    logic               sgn;
    logic signed [15:0] ex;   // value = man * 2^ex
    logic [63:0]        man;
  } fval_t;

  typedef struct {
    logic [31:0] operand;
    logic        known;
    logic [31:0] result;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 1400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_value_bits;
  logic        out_valid;
  logic [31:0] out_result_bits;

  logic [31:0] rsqrt_expected[$];
  int          mismatches;
  int          results_seen;
  int          idle_cycles;
  bit          quiet_tail;
  stim_row_t   dir_rows[$];

  fast_inverse_sqrt_float32 dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_value_bits(in_value_bits), .out_valid(out_valid),
    .out_result_bits(out_result_bits)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic fval_t f_unpack(logic [31:0] b);
    fval_t v;
    v.sgn = b[31];
    v.cls = FC_NUM;
    if (b[30:23] == 8'hff) v.cls = (b[22:0] != 0) ? FC_NAN : FC_INF;
    else if (b[30:0] == 0) v.cls = FC_ZERO;
    if (b[30:23] == 0) begin
      v.man = {41'd0, b[22:0]};
      v.ex  = -16'sd149;
    end else begin
      v.man = {40'd0, 1'b1, b[22:0]};
      v.ex  = 16'(int'(b[30:23]) - 150);
    end
    return v;
  endfunction

  // Round sign * m * 2^e (m nonzero) to float32, nearest even.
  function automatic logic [31:0] f_round(logic s, int e, logic [63:0] m);
    int p, sh, ee, bexp;
    logic [63:0] q;
    logic g, st;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    sh = (p + e + 127 >= 1) ? p - 23 : -149 - e;
    g = 1'b0;
    st = 1'b0;
    if (sh <= 0) q = m << (-sh);
    else if (sh > 64) begin
      q = 0;
      st = 1'b1;
    end else begin
      q  = (sh == 64) ? 64'd0 : m >> sh;
      g  = m[sh-1];
      st = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
    end
    q = q + 64'(g & (st | q[0]));
    ee = e + sh;
    if (q[24]) begin
      q = q >> 1;
      ee++;
    end
    if (!q[23]) return {s, 8'd0, q[22:0]};
    bexp = ee + 150;
    if (bexp >= 255) return {s, 8'hff, 23'd0};
    return {s, 8'(bexp), q[22:0]};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    fval_t x, y;
    logic s;
    x = f_unpack(a);
    y = f_unpack(b);
    s = x.sgn ^ y.sgn;
    if (x.cls == FC_NAN || y.cls == FC_NAN) return CANON_NAN;
    if ((x.cls == FC_INF && y.cls == FC_ZERO) || (x.cls == FC_ZERO && y.cls == FC_INF))
      return CANON_NAN;
    if (x.cls == FC_INF || y.cls == FC_INF) return {s, 8'hff, 23'd0};
    if (x.cls == FC_ZERO || y.cls == FC_ZERO) return {s, 31'd0};
    return f_round(s, int'(x.ex) + int'(y.ex), x.man * y.man);
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    fval_t x, y, big, sml;
    int d, e;
    logic [63:0] mb, ms, mag;
    logic s;
    x = f_unpack(a);
    y = f_unpack(b);
    y.sgn = ~y.sgn;
    if (x.cls == FC_NAN || y.cls == FC_NAN) return CANON_NAN;
    if (x.cls == FC_INF && y.cls == FC_INF)
      return (x.sgn == y.sgn) ? {x.sgn, 8'hff, 23'd0} : CANON_NAN;
    if (x.cls == FC_INF) return {x.sgn, 8'hff, 23'd0};
    if (y.cls == FC_INF) return {y.sgn, 8'hff, 23'd0};
    if (x.cls == FC_ZERO && y.cls == FC_ZERO) return {x.sgn & y.sgn, 31'd0};
    if (x.cls == FC_ZERO) return {y.sgn, b[30:0]};
    if (y.cls == FC_ZERO) return a;
    if (x.ex >= y.ex) begin
      big = x;
      sml = y;
    end else begin
      big = y;
      sml = x;
    end
    d = int'(big.ex) - int'(sml.ex);
    if (d <= 30) begin
      mb = big.man << d;
      ms = sml.man;
      e  = sml.ex;
    end else begin
      // far smaller operand only matters as a sticky bit
      mb = big.man << 30;
      ms = 64'd1;
      e  = int'(big.ex) - 30;
    end
    s = big.sgn;
    if (big.sgn == sml.sgn) mag = mb + ms;
    else if (mb >= ms) mag = mb - ms;
    else begin
      mag = ms - mb;
      s = sml.sgn;
    end
    if (mag == 0) return 32'd0;
    return f_round(s, e, mag);
  endfunction

  function automatic logic [31:0] rsqrt_approx(logic [31:0] xb);
    logic [31:0] guess, h, t, r;
    guess = MAGIC - (xb >> 1);
    h = f_mul(xb, F_HALF);
    t = f_mul(h, guess);
    t = f_mul(t, guess);
    t = f_sub(F_ONEHALF, t);
    r = f_mul(guess, t);
    if (r[30:23] == 8'hff && r[22:0] != 0) r = CANON_NAN;
    return r;
  endfunction

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1:    ; // raw pattern
      2:       v[30:23] = 8'd0;                       // subnormal or zero
      3:       v = {v[31], 8'hff, ($urandom_range(0, 1) ? 23'd0 : v[22:0])};
      4:       v[30:0] = ($urandom_range(0, 1)) ? 31'd0 : 31'd1;
      5:       v[30:23] = 8'($urandom_range(250, 254));
      default: begin
        v[31] = ($urandom_range(0, 7) == 0);
        v[30:23] = 8'($urandom_range(100, 154));
      end
    endcase
    return v;
  endfunction

  task automatic send_item(logic [31:0] v, logic known, logic [31:0] res);
    start <= 1'b1;
    in_value_bits <= v;
    do @(posedge clk); while (busy);
    rsqrt_expected.push_back(known ? res : rsqrt_approx(v));
  endtask

  task automatic maybe_idle();
    int n;
    if (quiet_tail || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 15);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // check results and watch for a stall
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (rsqrt_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h", out_result_bits);
      end else begin
        if (out_result_bits !== rsqrt_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", rsqrt_expected[0], out_result_bits);
        end
        void'(rsqrt_expected.pop_front());
      end
    end
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", rsqrt_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet_tail = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_value_bits = 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      '{32'h7fc00000, 1'b1, CANON_NAN},
      '{32'hffffffff, 1'b1, CANON_NAN},
      '{32'h7f800001, 1'b1, CANON_NAN},
      '{32'h7f800000, 1'b1, 32'hff800000},
      '{32'hff800000, 1'b0, 32'h0},
      '{32'h00000000, 1'b0, 32'h0},
      '{32'h80000000, 1'b0, 32'h0},
      '{32'h00000001, 1'b0, 32'h0},
      '{32'h007fffff, 1'b0, 32'h0},
      '{32'h00800000, 1'b0, 32'h0},
      '{32'h7f7fffff, 1'b0, 32'h0},
      '{32'h3f800000, 1'b0, 32'h0},
      '{32'h40800000, 1'b0, 32'h0},
      '{32'h3e800000, 1'b0, 32'h0},
      '{32'hbf800000, 1'b0, 32'h0},
      '{32'hc0800000, 1'b0, 32'h0},
      '{32'h80000001, 1'b0, 32'h0},
      '{32'hff7fffff, 1'b0, 32'h0},
      '{32'h5f3759df, 1'b0, 32'h0},
      '{32'hbeb6eb3e, 1'b0, 32'h0},
      '{32'h55555555, 1'b0, 32'h0},
      '{32'haaaaaaaa, 1'b0, 32'h0}
    };
    @(posedge clk);
    foreach (dir_rows[i]) send_item(dir_rows[i].operand, dir_rows[i].known, dir_rows[i].result);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // drain the pipe completely once
        start <= 1'b0;
        while (rsqrt_expected.size() != 0) @(posedge clk);
      end
      if (i == RANDOM_ITEMS - 200) quiet_tail = 1;
      maybe_idle();
      send_item(random_operand(), 1'b0, 32'd0);
    end
    start <= 1'b0;

    while (rsqrt_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: corner patterns, NaN/inf/zero/subnormal/negative mixes",
             results_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && rsqrt_expected.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
